>>> sv/plucked_string_voice_assert.svh
// Assertion macros for the plucked string voice.
// Both macros sample on the rising edge of clock and are disabled while reset is high.
`ifndef PLUCKED_STRING_VOICE_ASSERT_SVH
`define PLUCKED_STRING_VOICE_ASSERT_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define PSV_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("plucked_string_voice: same-cycle check failed");

// Next-cycle implication: cons must hold in the cycle after ante holds.
`define PSV_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("plucked_string_voice: next-cycle check failed");

`endif

>>> sv/psv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package psv_pkg;

   localparam int unsigned SAMPLE_RATE = 44100;
   localparam int unsigned LINE_DEPTH  = 131072;
   localparam int unsigned TWO_RATE    = 2 * SAMPLE_RATE;

   localparam int ADDR_W   = $clog2(LINE_DEPTH);
   localparam int PERIOD_W = $clog2(LINE_DEPTH + 1);
   localparam int NOTE_W   = 7;
   localparam int NOTE_NUM = 2 ** NOTE_W;
   localparam int TAPS_W   = 5;
   localparam int SAMPLE_W = 16;
   localparam int NOISE_W  = 32;

   localparam int MAX_TAPS   = 16;
   localparam int RESET_TAPS = 2;
   localparam int CNT_W      = $clog2(MAX_TAPS);

   localparam int SUM_W       = SAMPLE_W + CNT_W;
   localparam int DAMP_W      = 17;
   localparam int DAMP_SHIFT  = 16;
   localparam int PROD_W      = SUM_W + DAMP_W + 1;
   localparam int SCALED_W    = PROD_W - DAMP_SHIFT;
   localparam int MAG_W       = SUM_W;
   localparam int RECIP_SHIFT = MAG_W + CNT_W + 1;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int QPROD_W     = MAG_W + RECIP_W;
   localparam int QUOT_W      = QPROD_W - RECIP_SHIFT;

   localparam logic signed [DAMP_W:0] DAMP_MUL = (DAMP_W + 1)'(65339);

   localparam int SAMPLE_MAX     = 2 ** (SAMPLE_W - 1) - 1;
   localparam int SAMPLE_MIN_MAG = 2 ** (SAMPLE_W - 1);
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_HI = SAMPLE_W'(SAMPLE_MAX);
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_LO = SAMPLE_W'(SAMPLE_MIN_MAG);

   localparam logic [NOISE_W-1:0] NOISE_A_RESET = NOISE_W'(1237);
   localparam logic [NOISE_W-1:0] NOISE_B_RESET = NOISE_W'(234567);
   localparam logic [NOISE_W-1:0] NOISE_C_RESET = NOISE_W'(890123);

   localparam int unsigned RECIP_ONE = 2 ** RECIP_SHIFT;

   localparam logic [RECIP_W-1:0] RECIP_TABLE [MAX_TAPS] = '{
      RECIP_W'((RECIP_ONE + 0) / 1),   RECIP_W'((RECIP_ONE + 1) / 2),
      RECIP_W'((RECIP_ONE + 2) / 3),   RECIP_W'((RECIP_ONE + 3) / 4),
      RECIP_W'((RECIP_ONE + 4) / 5),   RECIP_W'((RECIP_ONE + 5) / 6),
      RECIP_W'((RECIP_ONE + 6) / 7),   RECIP_W'((RECIP_ONE + 7) / 8),
      RECIP_W'((RECIP_ONE + 8) / 9),   RECIP_W'((RECIP_ONE + 9) / 10),
      RECIP_W'((RECIP_ONE + 10) / 11), RECIP_W'((RECIP_ONE + 11) / 12),
      RECIP_W'((RECIP_ONE + 12) / 13), RECIP_W'((RECIP_ONE + 13) / 14),
      RECIP_W'((RECIP_ONE + 14) / 15), RECIP_W'((RECIP_ONE + 15) / 16)
   };

   function automatic logic [PERIOD_W-1:0] pclip(input int unsigned p);
      return (p > LINE_DEPTH) ? PERIOD_W'(LINE_DEPTH) : PERIOD_W'(p);
   endfunction

   localparam logic [PERIOD_W-1:0] PERIOD_TABLE [NOTE_NUM] = '{
      pclip(TWO_RATE / 1), pclip(TWO_RATE / 1), pclip(TWO_RATE / 1), pclip(TWO_RATE / 1),
      pclip(TWO_RATE / 1), pclip(TWO_RATE / 1), pclip(TWO_RATE / 1), pclip(TWO_RATE / 1),
      pclip(TWO_RATE / 1), pclip(TWO_RATE / 1), pclip(TWO_RATE / 1), pclip(TWO_RATE / 1),
      pclip(TWO_RATE / 2), pclip(TWO_RATE / 2), pclip(TWO_RATE / 2), pclip(TWO_RATE / 2),
      pclip(TWO_RATE / 2), pclip(TWO_RATE / 2), pclip(TWO_RATE / 2), pclip(TWO_RATE / 2),
      pclip(TWO_RATE / 3), pclip(TWO_RATE / 3), pclip(TWO_RATE / 3), pclip(TWO_RATE / 3),
      pclip(TWO_RATE / 4), pclip(TWO_RATE / 4), pclip(TWO_RATE / 4), pclip(TWO_RATE / 4),
      pclip(TWO_RATE / 5), pclip(TWO_RATE / 5), pclip(TWO_RATE / 5), pclip(TWO_RATE / 5),
      pclip(TWO_RATE / 6), pclip(TWO_RATE / 6), pclip(TWO_RATE / 7), pclip(TWO_RATE / 7),
      pclip(TWO_RATE / 8), pclip(TWO_RATE / 8), pclip(TWO_RATE / 8), pclip(TWO_RATE / 9),
      pclip(TWO_RATE / 10), pclip(TWO_RATE / 10), pclip(TWO_RATE / 11),
      pclip(TWO_RATE / 11), pclip(TWO_RATE / 12), pclip(TWO_RATE / 13),
      pclip(TWO_RATE / 14), pclip(TWO_RATE / 15),
      pclip(TWO_RATE / 16), pclip(TWO_RATE / 16), pclip(TWO_RATE / 17),
      pclip(TWO_RATE / 19), pclip(TWO_RATE / 20), pclip(TWO_RATE / 21),
      pclip(TWO_RATE / 22), pclip(TWO_RATE / 23), pclip(TWO_RATE / 25),
      pclip(TWO_RATE / 26), pclip(TWO_RATE / 28), pclip(TWO_RATE / 30),
      pclip(TWO_RATE / 32), pclip(TWO_RATE / 33), pclip(TWO_RATE / 35),
      pclip(TWO_RATE / 38), pclip(TWO_RATE / 40), pclip(TWO_RATE / 42),
      pclip(TWO_RATE / 45), pclip(TWO_RATE / 47), pclip(TWO_RATE / 50),
      pclip(TWO_RATE / 53), pclip(TWO_RATE / 57), pclip(TWO_RATE / 60),
      pclip(TWO_RATE / 64), pclip(TWO_RATE / 67), pclip(TWO_RATE / 71),
      pclip(TWO_RATE / 76), pclip(TWO_RATE / 80), pclip(TWO_RATE / 85),
      pclip(TWO_RATE / 90), pclip(TWO_RATE / 95), pclip(TWO_RATE / 101),
      pclip(TWO_RATE / 107), pclip(TWO_RATE / 114), pclip(TWO_RATE / 120),
      pclip(TWO_RATE / 128), pclip(TWO_RATE / 135), pclip(TWO_RATE / 143),
      pclip(TWO_RATE / 152), pclip(TWO_RATE / 161), pclip(TWO_RATE / 170),
      pclip(TWO_RATE / 181), pclip(TWO_RATE / 191), pclip(TWO_RATE / 203),
      pclip(TWO_RATE / 215), pclip(TWO_RATE / 228), pclip(TWO_RATE / 241),
      pclip(TWO_RATE / 256), pclip(TWO_RATE / 271), pclip(TWO_RATE / 287),
      pclip(TWO_RATE / 304), pclip(TWO_RATE / 322), pclip(TWO_RATE / 341),
      pclip(TWO_RATE / 362), pclip(TWO_RATE / 383), pclip(TWO_RATE / 406),
      pclip(TWO_RATE / 430), pclip(TWO_RATE / 456), pclip(TWO_RATE / 483),
      pclip(TWO_RATE / 512), pclip(TWO_RATE / 542), pclip(TWO_RATE / 574),
      pclip(TWO_RATE / 608), pclip(TWO_RATE / 645), pclip(TWO_RATE / 683),
      pclip(TWO_RATE / 724), pclip(TWO_RATE / 767), pclip(TWO_RATE / 812),
      pclip(TWO_RATE / 861), pclip(TWO_RATE / 912), pclip(TWO_RATE / 966),
      pclip(TWO_RATE / 1024), pclip(TWO_RATE / 1084), pclip(TWO_RATE / 1149),
      pclip(TWO_RATE / 1217), pclip(TWO_RATE / 1290), pclip(TWO_RATE / 1366),
      pclip(TWO_RATE / 1448), pclip(TWO_RATE / 1534)
   };

   typedef struct packed {
      logic take_note;
      logic take_tick;
      logic fill;
      logic issue;
      logic mul;
      logic scale;
      logic div;
      logic write_out;
      logic load_zero;
   } ctrl_cmd_type;

   typedef struct packed {
      logic no_note;
      logic fill_last;
      logic tap_last;
   } dp_status_type;

endpackage

`default_nettype wire

>>> sv/psv_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface psv_req_if import psv_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              mode;
   logic [NOTE_W-1:0] note;
   logic [TAPS_W-1:0] taps;

   modport source (output valid, output mode, output note, output taps, input ready);
   modport sink (input valid, input mode, input note, input taps, output ready);
endinterface

interface psv_rsp_if import psv_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

`default_nettype wire

>>> sv/psv_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module psv_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> sv/psv_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module psv_ctrl import psv_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          req_mode,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_FILL,
      S_READ,
      S_DRAIN,
      S_MUL,
      S_SCALE,
      S_DIV,
      S_OUT,
      S_ZERO
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      accept;
   logic      slot_free;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd           = '0;
      cmd.take_note = accept && req_mode;
      cmd.take_tick = accept && !req_mode;
      cmd.fill      = (state_ff == S_FILL);
      cmd.issue     = (state_ff == S_READ);
      cmd.mul       = (state_ff == S_MUL);
      cmd.scale     = (state_ff == S_SCALE);
      cmd.div       = (state_ff == S_DIV);
      cmd.write_out = (state_ff == S_OUT) && slot_free;
      cmd.load_zero = (state_ff == S_ZERO) && slot_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.write_out || cmd.load_zero) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (cmd.take_note) begin
                  state_ff <= S_FILL;
               end else if (cmd.take_tick) begin
                  state_ff <= status.no_note ? S_ZERO : S_READ;
               end
            end
            S_FILL: begin
               if (status.fill_last) begin
                  state_ff <= S_IDLE;
               end
            end
            S_READ: begin
               if (status.tap_last) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: state_ff <= S_MUL;
            S_MUL:   state_ff <= S_SCALE;
            S_SCALE: state_ff <= S_DIV;
            S_DIV:   state_ff <= S_OUT;
            S_OUT, S_ZERO: begin
               if (slot_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

>>> sv/psv_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module psv_dp import psv_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ctrl_cmd_type        cmd,
   input  wire logic [NOTE_W-1:0]   req_note,
   input  wire logic [TAPS_W-1:0]   req_taps,
   output dp_status_type            status,
   output logic signed [SAMPLE_W-1:0] rsp_sample
);

   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [ADDR_W-1:0]   pos_ff, pos_in;
   logic [CNT_W-1:0]    taps_m1_ff, taps_m1_in;
   logic [NOISE_W-1:0]  noise_a_ff, noise_a_in;
   logic [NOISE_W-1:0]  noise_b_ff, noise_b_in;
   logic [NOISE_W-1:0]  noise_c_ff, noise_c_in;
   logic                issue_d_ff;

   logic [ADDR_W-1:0]          addr_ff, addr_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic signed [PROD_W-1:0]   prod_ff;
   logic [MAG_W-1:0]           mag_ff;
   logic                       neg_ff;
   logic [QPROD_W-1:0]         qprod_ff;
   logic signed [SAMPLE_W-1:0] sample_ff;

   logic [NOISE_W-1:0]         noise_a_next;
   logic [PERIOD_W-1:0]        pos_inc;
   logic [PERIOD_W-1:0]        addr_inc;
   logic [ADDR_W-1:0]          next_pos;
   logic [ADDR_W-1:0]          next_addr;
   logic signed [SCALED_W-1:0] scaled;
   logic [SCALED_W-1:0]        scaled_mag;
   logic [QUOT_W-1:0]          quot;
   logic [QUOT_W-1:0]          quot_neg;
   logic signed [SAMPLE_W-1:0] avg;

   logic                ram_we;
   logic [ADDR_W-1:0]   ram_waddr;
   logic [SAMPLE_W-1:0] ram_wdata;
   logic [SAMPLE_W-1:0] ram_rdata;

   assign noise_a_next = noise_a_ff + noise_b_ff;

   assign pos_inc   = PERIOD_W'(pos_ff) + PERIOD_W'(1);
   assign next_pos  = (pos_inc == period_ff) ? '0 : ADDR_W'(pos_inc);
   assign addr_inc  = PERIOD_W'(addr_ff) + PERIOD_W'(1);
   assign next_addr = (addr_inc == period_ff) ? '0 : ADDR_W'(addr_inc);

   assign status.no_note   = (period_ff == '0);
   assign status.fill_last = (addr_inc == period_ff);
   assign status.tap_last  = (cnt_ff == taps_m1_ff);

   assign scaled     = signed'(prod_ff[PROD_W-1:DAMP_SHIFT]);
   assign scaled_mag = scaled[SCALED_W-1] ? SCALED_W'(-scaled) : SCALED_W'(scaled);

   assign quot     = qprod_ff[QPROD_W-1:RECIP_SHIFT];
   assign quot_neg = QUOT_W'(0) - quot;

   always_comb begin
      if (!neg_ff) begin
         avg = (quot > QUOT_W'(SAMPLE_MAX)) ? SAMPLE_HI : SAMPLE_W'(quot);
      end else begin
         avg = (quot > QUOT_W'(SAMPLE_MIN_MAG)) ? SAMPLE_LO : SAMPLE_W'(quot_neg);
      end
   end

   always_comb begin
      period_in  = period_ff;
      pos_in     = pos_ff;
      taps_m1_in = taps_m1_ff;
      noise_a_in = noise_a_ff;
      noise_b_in = noise_b_ff;
      noise_c_in = noise_c_ff;
      addr_in    = addr_ff;
      cnt_in     = cnt_ff;
      sum_in     = sum_ff;

      if (cmd.take_note) begin
         period_in = PERIOD_TABLE[req_note];
         pos_in    = '0;
         addr_in   = '0;
         if (req_taps == '0) begin
            taps_m1_in = '0;
         end else if (req_taps > TAPS_W'(MAX_TAPS)) begin
            taps_m1_in = CNT_W'(MAX_TAPS - 1);
         end else begin
            taps_m1_in = CNT_W'(req_taps - TAPS_W'(1));
         end
      end

      if (cmd.take_tick) begin
         pos_in  = next_pos;
         addr_in = next_pos;
         cnt_in  = '0;
         sum_in  = '0;
      end

      if (cmd.fill) begin
         noise_a_in = noise_a_next;
         noise_b_in = noise_b_ff + noise_c_ff;
         noise_c_in = noise_c_ff + noise_a_next;
         addr_in    = next_addr;
      end

      if (cmd.issue) begin
         addr_in = next_addr;
         cnt_in  = cnt_ff + CNT_W'(1);
      end

      if (issue_d_ff) begin
         sum_in = sum_ff + SUM_W'(signed'(ram_rdata));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff  <= '0;
         pos_ff     <= '0;
         taps_m1_ff <= CNT_W'(RESET_TAPS - 1);
         noise_a_ff <= NOISE_A_RESET;
         noise_b_ff <= NOISE_B_RESET;
         noise_c_ff <= NOISE_C_RESET;
         issue_d_ff <= 1'b0;
      end else begin
         period_ff  <= period_in;
         pos_ff     <= pos_in;
         taps_m1_ff <= taps_m1_in;
         noise_a_ff <= noise_a_in;
         noise_b_ff <= noise_b_in;
         noise_c_ff <= noise_c_in;
         issue_d_ff <= cmd.issue;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      cnt_ff  <= cnt_in;
      sum_ff  <= sum_in;
      if (cmd.mul) begin
         prod_ff <= PROD_W'(sum_ff) * PROD_W'(DAMP_MUL);
      end
      if (cmd.scale) begin
         mag_ff <= MAG_W'(scaled_mag);
         neg_ff <= scaled[SCALED_W-1];
      end
      if (cmd.div) begin
         qprod_ff <= QPROD_W'(mag_ff) * QPROD_W'(RECIP_TABLE[taps_m1_ff]);
      end
      if (cmd.write_out) begin
         sample_ff <= avg;
      end else if (cmd.load_zero) begin
         sample_ff <= '0;
      end
   end

   assign ram_we    = cmd.fill || cmd.write_out;
   assign ram_waddr = cmd.fill ? addr_ff : pos_ff;
   assign ram_wdata = cmd.fill ? noise_a_next[NOISE_W-1 -: SAMPLE_W] : avg;

   psv_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (LINE_DEPTH)
   ) u_line (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (addr_ff),
      .rd_data (ram_rdata)
   );

   assign rsp_sample = sample_ff;

endmodule

`default_nettype wire

>>> sv/plucked_string_voice.sv
// Plucked string voice: one Karplus-Strong voice on signed Q1.15 samples.
// req_chan carries a command (mode, note, taps); rsp_chan carries one sample.
// A transfer happens on either channel when valid and ready are both high.
// Note-on (mode 1) loads the period for the note and fills the delay line
// with noise, one entry per cycle from the single write port of the line
// memory; no sample is produced.
// Tick (mode 0) reads taps entries one per cycle from the read port, then
// damps (one multiply), divides by taps (reciprocal multiply) and saturates.
// A tick before any note skips the line and gives 0 from state S_ZERO.
// One command is in flight at a time; req_chan.ready is high only when idle.
// The finished sample sits in an output register, so the next command is taken
// while it waits; if the receiver stalls with that register still full, the
// next tick holds at its final step until the sample has been taken.
// Reset zeroes the period (no note) and position, sets taps to 2 and reloads
// the noise seeds. The delay line itself is not cleared; each entry is filled
// by a note-on before it is read.
`timescale 1ns / 1ps
`default_nettype none

`include "plucked_string_voice_assert.svh"

module plucked_string_voice import psv_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   psv_req_if.sink    req_chan,
   psv_rsp_if.source  rsp_chan
);

   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;

   psv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_mode  (req_chan.mode),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   psv_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (ctrl_cmd),
      .req_note   (req_chan.note),
      .req_taps   (req_chan.taps),
      .status     (dp_status),
      .rsp_sample (rsp_chan.sample)
   );

   `PSV_ASSERT_NEXT(busy_after_accept, req_chan.valid && req_chan.ready, !req_chan.ready)
   `PSV_ASSERT_NEXT(note_sets_period, ctrl_cmd.take_note, !dp_status.no_note)
   `PSV_ASSERT_IMPL(line_use_needs_note, ctrl_cmd.issue || ctrl_cmd.write_out, !dp_status.no_note)

endmodule

`default_nettype wire
